[rtl/rbf_pkg.sv]
// shared types, constants and the 2^-f lookup table for the rbf kernel evaluator
// no dependencies; imported by every module of the block
package rbf_pkg;

  // payload of the two channels
  typedef struct packed {
    logic signed [15:0] x_coord;
    logic signed [15:0] c_coord;
    logic               last_dim;
  } in_item_t;

  typedef struct packed {
    logic [15:0] kernel_value;
    logic        dist_saturated;
  } out_item_t;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAMMA = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 1'd1;
  localparam int CFG_DATA_W = 24;
  localparam logic [23:0] GAMMA_RESET = 24'd65536;
  localparam logic [15:0] ALPHA_RESET = 16'd256;

  // defaults for the top level parameters
  localparam int MAX_DIMS_DEF = 64;

  // distance accumulator
  localparam int SUM_W = 40;

  typedef struct packed {
    logic [SUM_W-1:0] dist_sum;
    logic             dist_sat;
  } dist_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  localparam int Q_DEPTH = 2;

  // exp evaluation constants
  localparam logic [16:0] LOG2E_Q16 = 17'd94548;
  localparam logic [47:0] ARG_LIMIT = 48'(17) << 16;
  localparam logic [63:0] LN2_Q30   = 64'd744261118;
  localparam logic [63:0] ONE_Q30   = 64'd1 << 30;

  // 2^(-i/EXP_N) in q16, entries 0..EXP_N
  localparam int EXP_N    = 64;
  localparam int TBL_AW   = $clog2(EXP_N + 1);
  typedef logic [16:0] pow2_t;
  typedef pow2_t [EXP_N:0] pow2_tbl_t;

  function automatic logic [63:0] div_small(input logic [63:0] v, input int n);
    logic [63:0] q;
    case (n)
      1:       q = v;
      2:       q = v / 2;
      3:       q = v / 3;
      4:       q = v / 4;
      5:       q = v / 5;
      6:       q = v / 6;
      7:       q = v / 7;
      8:       q = v / 8;
      9:       q = v / 9;
      10:      q = v / 10;
      11:      q = v / 11;
      12:      q = v / 12;
      13:      q = v / 13;
      14:      q = v / 14;
      15:      q = v / 15;
      16:      q = v / 16;
      default: q = v;
    endcase
    return q;
  endfunction

  // taylor series of exp(-i*ln2/EXP_N) in q30, rounded to q16
  function automatic pow2_tbl_t build_pow2_tbl();
    pow2_tbl_t          tbl;
    logic [63:0]        xv;
    logic [63:0]        term;
    logic [63:0]        prod;
    logic signed [63:0] acc;
    for (int i = 0; i <= EXP_N; i++) begin
      xv   = (64'(i) * LN2_Q30) / EXP_N;
      term = ONE_Q30;
      acc  = $signed(ONE_Q30);
      for (int n = 1; n <= 16; n++) begin
        prod = (term * xv) >> 30;
        term = div_small(prod, n);
        if ((n & 1) != 0) begin
          acc = acc - $signed(term);
        end else begin
          acc = acc + $signed(term);
        end
      end
      if (acc < 0) begin
        acc = '0;
      end
      tbl[i] = 17'((acc + 64'sd8192) >>> 14);
    end
    return tbl;
  endfunction

  localparam pow2_tbl_t POW2_TBL = build_pow2_tbl();

endpackage

[rtl/rbf_front.sv]
// front end: squares each coordinate difference and keeps the saturating distance sum
// depends on rbf_pkg; hands one finished distance per point pair to rbf_queue
module rbf_front #(
  parameter int MAX_DIMS = rbf_pkg::MAX_DIMS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rbf_pkg::in_item_t   in_data,
  input  rbf_pkg::q_stat_t    q_stat,
  output logic                push,
  output rbf_pkg::dist_item_t push_item
);
  import rbf_pkg::*;

  localparam int DIM_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

  logic [DIM_W-1:0] dim_cnt_r, dim_cnt_nxt;
  logic             a_vld_r, a_vld_nxt;
  logic             a_last_r, a_last_nxt;
  logic [31:0]      sq_r, sq_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic             sat_r, sat_nxt;

  logic              in_acc;
  logic              a_blocked;
  logic              a_adv;
  logic              eff_last;
  logic signed [16:0] diff;
  logic [15:0]       abs_diff;
  logic [SUM_W:0]    sum_add;
  logic [SUM_W-1:0]  sum_new;
  logic              sat_new;

  // a closing transaction waits while the queue is full
  assign a_blocked = a_last_r && q_stat.full;
  assign a_adv     = a_vld_r && !a_blocked;
  assign in_stall  = a_vld_r && a_blocked;
  assign in_acc    = in_valid && !in_stall;

  assign eff_last = in_data.last_dim || (dim_cnt_r == DIM_W'(MAX_DIMS - 1));
  assign diff     = {in_data.x_coord[15], in_data.x_coord}
                  - {in_data.c_coord[15], in_data.c_coord};
  assign abs_diff = diff[16] ? 16'(-diff) : diff[15:0];

  assign sum_add = {1'b0, sum_r} + {{(SUM_W - 31){1'b0}}, sq_r};
  assign sum_new = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
  assign sat_new = sat_r || sum_add[SUM_W];

  assign push               = a_adv && a_last_r;
  assign push_item.dist_sum = sum_new;
  assign push_item.dist_sat = sat_new;

  always_comb begin
    a_vld_nxt   = a_vld_r;
    a_last_nxt  = a_last_r;
    sq_nxt      = sq_r;
    dim_cnt_nxt = dim_cnt_r;
    sum_nxt     = sum_r;
    sat_nxt     = sat_r;
    if (a_adv) begin
      a_vld_nxt = 1'b0;
      if (a_last_r) begin
        sum_nxt = '0;
        sat_nxt = 1'b0;
      end else begin
        sum_nxt = sum_new;
        sat_nxt = sat_new;
      end
    end
    if (in_acc) begin
      a_vld_nxt   = 1'b1;
      a_last_nxt  = eff_last;
      sq_nxt      = abs_diff * abs_diff;
      dim_cnt_nxt = eff_last ? '0 : dim_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r   <= 1'b0;
      dim_cnt_r <= '0;
      sum_r     <= '0;
      sat_r     <= 1'b0;
    end else begin
      a_vld_r   <= a_vld_nxt;
      dim_cnt_r <= dim_cnt_nxt;
      sum_r     <= sum_nxt;
      sat_r     <= sat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_last_r <= a_last_nxt;
    sq_r     <= sq_nxt;
  end

endmodule

[rtl/rbf_queue.sv]
// small fifo of finished distance sums between front and back end
// depends on rbf_pkg
module rbf_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  rbf_pkg::dist_item_t push_item,
  input  logic                pop,
  output rbf_pkg::dist_item_t pop_item,
  output rbf_pkg::q_stat_t    q_stat
);
  import rbf_pkg::*;

  localparam int QAW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int QCW = $clog2(Q_DEPTH + 1);

  dist_item_t       slot_r [Q_DEPTH];
  logic [QAW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0]   cnt_r, cnt_nxt;

  assign q_stat.full  = (cnt_r == QCW'(Q_DEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign pop_item     = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QAW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QAW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

[rtl/rbf_back.sv]
// back end: sequencer that turns one distance sum into alpha*exp(-gamma*dist)
// depends on rbf_pkg (table and constants); fed by rbf_queue, drives the result channel
module rbf_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [23:0]         gamma_scale,
  input  logic [15:0]         alpha_gain,
  input  rbf_pkg::q_stat_t    q_stat,
  input  rbf_pkg::dist_item_t pop_item,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output rbf_pkg::out_item_t  out_data
);
  import rbf_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_MLO    = 9'b000000010,
    ST_MHI    = 9'b000000100,
    ST_ARG    = 9'b000001000,
    ST_LOG2   = 9'b000010000,
    ST_TBL    = 9'b000100000,
    ST_INTERP = 9'b001000000,
    ST_SHIFT  = 9'b010000000,
    ST_SCALE  = 9'b100000000
  } back_st_t;

  back_st_t st_r, st_nxt;

  logic [SUM_W-1:0] sum_r;
  logic             sat_r;
  logic [43:0]      plo_r;
  logic [43:0]      phi_r;
  logic             big_r;
  logic [20:0]      arg_r;
  logic [21:0]      y_r;
  logic [16:0]      a_r;
  logic [16:0]      dif_r;
  logic [15:0]      fr_r;
  logic [16:0]      e0_r;
  logic [15:0]      e_r;
  logic             out_vld_r, out_vld_nxt;
  out_item_t        out_r;

  logic [63:0]          prod_full;
  logic [47:0]          arg_full;
  logic [37:0]          y_full;
  logic [16+TBL_AW-1:0] p_val;
  logic [TBL_AW-1:0]    idx;
  pow2_t                tbl_a;
  pow2_t                tbl_b;
  logic [32:0]          corr;
  logic [16:0]          e_shift;
  logic [32:0]          kv_full;
  logic                 out_free;

  assign pop      = (st_r == ST_IDLE) && !q_stat.empty;
  assign out_free = !out_vld_r || !out_stall;

  // q24.16 distance times q8.16 gamma, upper and lower halves summed
  assign prod_full = {phi_r, 20'd0} + {20'd0, plo_r};
  assign arg_full  = prod_full[63:16];
  assign y_full    = arg_r * LOG2E_Q16;

  // fraction split into table index and interpolation weight
  assign p_val = (16+TBL_AW)'(y_r[15:0]) * (16+TBL_AW)'(EXP_N);
  assign idx   = p_val[16 +: TBL_AW];
  assign tbl_a = POW2_TBL[idx];
  assign tbl_b = POW2_TBL[idx + 1'b1];

  assign corr    = dif_r * fr_r;
  assign e_shift = e0_r >> y_r[21:16];
  assign kv_full = alpha_gain * e_r + 33'd32768;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE:   if (!q_stat.empty) st_nxt = ST_MLO;
      ST_MLO:    st_nxt = ST_MHI;
      ST_MHI:    st_nxt = ST_ARG;
      ST_ARG:    st_nxt = ST_LOG2;
      ST_LOG2:   st_nxt = ST_TBL;
      ST_TBL:    st_nxt = ST_INTERP;
      ST_INTERP: st_nxt = ST_SHIFT;
      ST_SHIFT:  st_nxt = ST_SCALE;
      ST_SCALE:  if (out_free) st_nxt = ST_IDLE;
      default:   st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if ((st_r == ST_SCALE) && out_free) begin
      out_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      ST_IDLE: begin
        sum_r <= pop_item.dist_sum;
        sat_r <= pop_item.dist_sat;
      end
      ST_MLO:  plo_r <= sum_r[19:0] * gamma_scale;
      ST_MHI:  phi_r <= sum_r[39:20] * gamma_scale;
      ST_ARG: begin
        big_r <= (arg_full >= ARG_LIMIT);
        arg_r <= arg_full[20:0];
      end
      ST_LOG2: y_r <= y_full[37:16];
      ST_TBL: begin
        a_r   <= tbl_a;
        dif_r <= tbl_a - tbl_b;
        fr_r  <= p_val[15:0];
      end
      ST_INTERP: e0_r <= a_r - corr[32:16];
      ST_SHIFT: begin
        if (big_r) begin
          e_r <= '0;
        end else if (e_shift[16]) begin
          e_r <= 16'hFFFF;
        end else begin
          e_r <= e_shift[15:0];
        end
      end
      ST_SCALE: begin
        if (out_free) begin
          out_r.kernel_value   <= kv_full[32] ? 16'hFFFF : kv_full[31:16];
          out_r.dist_saturated <= sat_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

[rtl/rbf_kernel_evaluator_core.sv]
// top level of the gaussian rbf kernel evaluator: config registers, front, queue, back
// depends on rbf_pkg, rbf_front, rbf_queue and rbf_back
//
// Computes alpha * exp(-gamma * ||x - c||^2) for one point pair at a time. Each
// input transaction carries one coordinate pair (signed q8.8) and a last_dim mark;
// the front end accepts one coordinate every cycle unless a full queue stalls it,
// squares the difference and adds it into a 40-bit sum that saturates at all ones
// and sets dist_saturated. A pair closes on last_dim or on its MAX_DIMS-th
// coordinate, whichever comes first, and then exactly one result transaction
// follows. The closed sum goes through a two-entry queue to the exp back end, a
// sequencer that does two 20x24 partial products for the gamma scaling, a log2(e)
// multiply, a table lookup with linear interpolation, the power-of-two shift and
// the alpha scaling; a full queue holds the front end back. A finished result sits
// in an output register, so the back end starts the next pair while it waits to be
// taken. kernel_value is unsigned q8.8, saturated at 16 bits. gamma_scale (index
// 0, unsigned q8.16) and alpha_gain (index 1, unsigned q8.8) are written through
// cfg_we/cfg_index/cfg_wdata; the user must write them only while the block is
// idle, which the block does not enforce. There is no clearing pass after reset.
module rbf_kernel_evaluator_core #(
  parameter int MAX_DIMS = rbf_pkg::MAX_DIMS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  rbf_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output rbf_pkg::out_item_t                out_data,
  input  logic                              cfg_we,
  input  logic [rbf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rbf_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import rbf_pkg::*;

  // configuration registers
  logic [23:0] gamma_r, gamma_nxt;
  logic [15:0] alpha_r, alpha_nxt;

  // front to queue
  logic       push;
  dist_item_t push_item;

  // queue to back
  logic       pop;
  dist_item_t pop_item;
  q_stat_t    q_stat;

  always_comb begin
    gamma_nxt = gamma_r;
    alpha_nxt = alpha_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_GAMMA: gamma_nxt = cfg_wdata[23:0];
        CFG_ALPHA: alpha_nxt = cfg_wdata[15:0];
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gamma_r <= GAMMA_RESET;
      alpha_r <= ALPHA_RESET;
    end else begin
      gamma_r <= gamma_nxt;
      alpha_r <= alpha_nxt;
    end
  end

  // per-coordinate square and accumulate, one transaction per cycle unless stalled by a full queue
  rbf_front #(
    .MAX_DIMS (MAX_DIMS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .q_stat    (q_stat),
    .push      (push),
    .push_item (push_item)
  );

  // decouples the streaming front from the multi-cycle back end
  rbf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .q_stat    (q_stat)
  );

  // exp evaluation and alpha scaling, one pair at a time
  rbf_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .gamma_scale (gamma_r),
    .alpha_gain  (alpha_r),
    .q_stat      (q_stat),
    .pop_item    (pop_item),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule
